[hw/rtl/rps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_pkg
// Shared types, command and register codes, and pattern tables of the relay
// pattern sequencer.
// ----------------------------------------------------------------------------
package rps_pkg;

  // default parameter values
  localparam int TIME_BITS_DEF    = 16;
  localparam int PRESET_COUNT_DEF = 8;
  localparam int PRESET_STEPS_DEF = 10;

  // payload widths fixed by the item format
  localparam int CMD_W     = 4;
  localparam int PIDX_W    = 3;
  localparam int MODE_W    = 3;
  localparam int STEP_W    = 4;
  localparam int PULSE_W   = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DUR_W     = 17;
  localparam int ROM_ROWS  = 8;
  localparam int ROM_COLS  = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_STOP      = 4'd1;
  localparam logic [CMD_W-1:0] CMD_SET       = 4'd2;
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = 4'd3;
  localparam logic [CMD_W-1:0] CMD_BLINK     = 4'd4;
  localparam logic [CMD_W-1:0] CMD_TICK_MODE = 4'd5;
  localparam logic [CMD_W-1:0] CMD_BEAT      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_BURST     = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PRESET    = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_ON     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_PULSE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_ON    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_OFF   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_GAP   = 3'd7;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE   = 3'd0,
    MODE_BLINK  = 3'd1,
    MODE_TICK   = 3'd2,
    MODE_BEAT   = 3'd3,
    MODE_BURST  = 3'd4,
    MODE_PRESET = 3'd5
  } mode_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              manual_level;
    logic [PIDX_W-1:0] preset_index;
    logic              driver_ready;
  } cmd_req_t;

  typedef struct packed {
    logic              relay_level;
    logic [MODE_W-1:0] active_mode;
    logic              accepted;
  } result_t;

  typedef struct packed {
    logic [CFG_W-1:0]   blink_on_time;
    logic [CFG_W-1:0]   blink_off_time;
    logic [CFG_W-1:0]   tick_on_time;
    logic [CFG_W-1:0]   tick_period;
    logic [PULSE_W-1:0] burst_pulses;
    logic [CFG_W-1:0]   burst_on_time;
    logic [CFG_W-1:0]   burst_off_time;
    logic [CFG_W-1:0]   burst_gap;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    blink_on_time:  16'd2000,
    blink_off_time: 16'd2000,
    tick_on_time:   16'd200,
    tick_period:    16'd2000,
    burst_pulses:   8'd3,
    burst_on_time:  16'd200,
    burst_off_time: 16'd200,
    burst_gap:      16'd2000
  };

  localparam logic [CFG_W-1:0] BEAT_STEPS [4] = '{16'd250, 16'd250, 16'd250, 16'd2250};

  // even steps on, odd steps off; unused columns are zero
  localparam logic [CFG_W-1:0] PRESET_ROM [ROM_ROWS][ROM_COLS] = '{
    '{16'd2000, 16'd2000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd5000, 16'd5000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd250, 16'd2750, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd1000, 16'd3000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd3000, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd250, 16'd250, 16'd250, 16'd2250, 16'd0, 16'd0, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd250, 16'd250, 16'd250, 16'd250, 16'd250, 16'd1750, 16'd0, 16'd0,
      16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd250, 16'd250, 16'd250, 16'd250, 16'd250, 16'd750, 16'd750, 16'd250,
      16'd750, 16'd1750, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  localparam logic [STEP_W-1:0] PRESET_LEN [ROM_ROWS] = '{
    4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd4, 4'd6, 4'd10
  };

  function automatic logic [CFG_W-1:0] nz16(logic [CFG_W-1:0] v);
    return (v == '0) ? CFG_W'(1) : v;
  endfunction

  function automatic logic [PULSE_W-1:0] nz8(logic [PULSE_W-1:0] v);
    return (v == '0) ? PULSE_W'(1) : v;
  endfunction

endpackage

[hw/rtl/rps_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface rps_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rps_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_cfg_regs
// Pattern timing registers, written through the plain write port.
// ----------------------------------------------------------------------------
module rps_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rps_pkg::CFG_W-1:0]      cfg_data,
  output rps_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= rps_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rps_pkg::REG_BLINK_ON:    cfg.blink_on_time  <= cfg_data;
        rps_pkg::REG_BLINK_OFF:   cfg.blink_off_time <= cfg_data;
        rps_pkg::REG_TICK_ON:     cfg.tick_on_time   <= cfg_data;
        rps_pkg::REG_TICK_PERIOD: cfg.tick_period    <= cfg_data;
        rps_pkg::REG_BURST_PULSE: cfg.burst_pulses   <= cfg_data[rps_pkg::PULSE_W-1:0];
        rps_pkg::REG_BURST_ON:    cfg.burst_on_time  <= cfg_data;
        rps_pkg::REG_BURST_OFF:   cfg.burst_off_time <= cfg_data;
        rps_pkg::REG_BURST_GAP:   cfg.burst_gap      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/rps_seq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_seq_core
// Sequencer state and its single-pass update: decodes one request, advances,
// restarts or stops the pattern and loads the step duration.
// ----------------------------------------------------------------------------
module rps_seq_core #(
  parameter int TIME_BITS    = rps_pkg::TIME_BITS_DEF,
  parameter int PRESET_COUNT = rps_pkg::PRESET_COUNT_DEF,
  parameter int PRESET_STEPS = rps_pkg::PRESET_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  rps_pkg::cmd_req_t req,
  input  rps_pkg::cfg_t     cfg,
  output rps_pkg::result_t  res
);

  localparam int CW  = (TIME_BITS > rps_pkg::DUR_W) ? TIME_BITS : rps_pkg::DUR_W;
  localparam int STW = rps_pkg::STEP_W;

  // state registers
  rps_pkg::mode_t                   mode, mode_next;
  logic                             relay, relay_next;
  logic                             saved_level, saved_level_next;
  logic                             saved_valid, saved_valid_next;
  logic [TIME_BITS-1:0]             countdown, countdown_next;
  logic [STW-1:0]                   step, step_next;
  logic [rps_pkg::PULSE_W-1:0]      pulse_cnt, pulse_cnt_next;
  logic [rps_pkg::PIDX_W-1:0]       chosen, chosen_next;

  logic                             accepted;
  logic                             do_load;
  logic                             refuse;
  logic [STW:0]                     step_inc;
  logic [STW:0]                     preset_len;
  logic [rps_pkg::PULSE_W-1:0]      pulse_inc;

  // step load
  logic                             ld_on;
  logic [rps_pkg::DUR_W-1:0]        dur, dur_nz;
  logic [rps_pkg::DUR_W-1:0]        tick_on, tick_per, tick_per_fix;
  logic [CW-1:0]                    dur_w, dur_max;
  logic [TIME_BITS-1:0]             ld_count;

  assign step_inc  = {1'b0, step} + (STW+1)'(1);
  assign pulse_inc = pulse_cnt + rps_pkg::PULSE_W'(1);
  assign preset_len = ({1'b0, rps_pkg::PRESET_LEN[chosen]} < (STW+1)'(PRESET_STEPS)) ?
                      {1'b0, rps_pkg::PRESET_LEN[chosen]} : (STW+1)'(PRESET_STEPS);
  assign refuse = !req.driver_ready ||
                  ((req.command == rps_pkg::CMD_PRESET) &&
                   ({2'b00, req.preset_index} >= 5'(PRESET_COUNT)));

  always_comb begin
    mode_next        = mode;
    relay_next       = relay;
    saved_level_next = saved_level;
    saved_valid_next = saved_valid;
    countdown_next   = countdown;
    step_next        = step;
    pulse_cnt_next   = pulse_cnt;
    chosen_next      = chosen;
    accepted         = 1'b1;
    do_load          = 1'b0;

    unique case (req.command) inside
      rps_pkg::CMD_TICK: begin
        if (mode != rps_pkg::MODE_NONE) begin
          if (countdown <= TIME_BITS'(1)) begin
            do_load = 1'b1;
            unique case (mode)
              rps_pkg::MODE_BLINK, rps_pkg::MODE_TICK: begin
                step_next = {{(STW-1){1'b0}}, ~step[0]};
              end
              rps_pkg::MODE_BEAT: begin
                step_next = {2'b00, step[1:0] + 2'd1};
              end
              rps_pkg::MODE_BURST: begin
                if (step == STW'(0)) begin
                  step_next = STW'(1);
                end else if (step == STW'(1)) begin
                  if ((pulse_inc < rps_pkg::nz8(cfg.burst_pulses)) && (pulse_inc != '0)) begin
                    pulse_cnt_next = pulse_inc;
                    step_next      = STW'(0);
                  end else begin
                    pulse_cnt_next = '0;
                    step_next      = (cfg.burst_gap != '0) ? STW'(2) : STW'(0);
                  end
                end else begin
                  pulse_cnt_next = '0;
                  step_next      = STW'(0);
                end
              end
              rps_pkg::MODE_PRESET: begin
                step_next = (step_inc < preset_len) ? step_inc[STW-1:0] : STW'(0);
              end
              default: do_load = 1'b0;
            endcase
          end else begin
            countdown_next = countdown - TIME_BITS'(1);
          end
        end
      end
      rps_pkg::CMD_STOP, rps_pkg::CMD_SET, rps_pkg::CMD_TOGGLE: begin
        mode_next      = rps_pkg::MODE_NONE;
        chosen_next    = '0;
        step_next      = '0;
        countdown_next = '0;
        pulse_cnt_next = '0;
        if (saved_valid) begin
          relay_next       = saved_level;
          saved_valid_next = 1'b0;
        end
        if (req.command == rps_pkg::CMD_SET) begin
          relay_next = req.manual_level;
        end else if (req.command == rps_pkg::CMD_TOGGLE) begin
          relay_next = ~relay_next;
        end
      end
      rps_pkg::CMD_BLINK, rps_pkg::CMD_TICK_MODE, rps_pkg::CMD_BEAT,
      rps_pkg::CMD_BURST, rps_pkg::CMD_PRESET: begin
        if (refuse) begin
          accepted = 1'b0;
        end else begin
          if (!saved_valid) begin
            saved_level_next = relay;
            saved_valid_next = 1'b1;
          end
          unique case (req.command)
            rps_pkg::CMD_BLINK:     mode_next = rps_pkg::MODE_BLINK;
            rps_pkg::CMD_TICK_MODE: mode_next = rps_pkg::MODE_TICK;
            rps_pkg::CMD_BEAT:      mode_next = rps_pkg::MODE_BEAT;
            rps_pkg::CMD_BURST:     mode_next = rps_pkg::MODE_BURST;
            default: begin
              mode_next   = rps_pkg::MODE_PRESET;
              chosen_next = req.preset_index;
            end
          endcase
          step_next      = '0;
          pulse_cnt_next = '0;
          do_load        = 1'b1;
        end
      end
      default: accepted = 1'b0;
    endcase

    if (do_load) begin
      relay_next     = ld_on;
      countdown_next = ld_count;
    end
  end

  // duration of the step being entered
  assign tick_on      = {1'b0, rps_pkg::nz16(cfg.tick_on_time)};
  assign tick_per     = {1'b0, rps_pkg::nz16(cfg.tick_period)};
  assign tick_per_fix = (tick_per <= tick_on) ? tick_on + rps_pkg::DUR_W'(1) : tick_per;

  always_comb begin
    ld_on = ~step_next[0];
    dur   = rps_pkg::DUR_W'(1);
    case (mode_next)
      rps_pkg::MODE_BLINK: begin
        dur = {1'b0, ld_on ? rps_pkg::nz16(cfg.blink_on_time) :
                             rps_pkg::nz16(cfg.blink_off_time)};
      end
      rps_pkg::MODE_TICK: begin
        dur = ld_on ? tick_on : tick_per_fix - tick_on;
      end
      rps_pkg::MODE_BEAT: begin
        dur = {1'b0, rps_pkg::BEAT_STEPS[step_next[1:0]]};
      end
      rps_pkg::MODE_BURST: begin
        // pause step after the last pulse
        if (step_next == STW'(2)) begin
          ld_on = 1'b0;
          dur   = {1'b0, cfg.burst_gap};
        end else begin
          dur = {1'b0, ld_on ? rps_pkg::nz16(cfg.burst_on_time) :
                               rps_pkg::nz16(cfg.burst_off_time)};
        end
      end
      rps_pkg::MODE_PRESET: begin
        dur = {1'b0, rps_pkg::PRESET_ROM[chosen_next][step_next]};
      end
      default: ;
    endcase
  end

  assign dur_nz   = (dur == '0) ? rps_pkg::DUR_W'(1) : dur;
  assign dur_w    = CW'(dur_nz);
  assign dur_max  = CW'({TIME_BITS{1'b1}});
  assign ld_count = (dur_w > dur_max) ? dur_max[TIME_BITS-1:0] : dur_w[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= rps_pkg::MODE_NONE;
      relay       <= 1'b0;
      saved_level <= 1'b0;
      saved_valid <= 1'b0;
      countdown   <= '0;
      step        <= '0;
      pulse_cnt   <= '0;
      chosen      <= '0;
    end else if (fire) begin
      mode        <= mode_next;
      relay       <= relay_next;
      saved_level <= saved_level_next;
      saved_valid <= saved_valid_next;
      countdown   <= countdown_next;
      step        <= step_next;
      pulse_cnt   <= pulse_cnt_next;
      chosen      <= chosen_next;
    end
  end

  assign res.relay_level = relay_next;
  assign res.active_mode = mode_next;
  assign res.accepted    = accepted;

endmodule

[hw/rtl/relay_pattern_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_pattern_sequencer_unit
// Drives one relay output in timed on/off patterns from a command stream.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one request per item: a 1 ms tick, stop, set or toggle of
//   the manual level, or a start of blink, tick, beat, burst or preset mode.
//   res returns exactly one result per request: relay level, active mode and
//   whether the command took effect. Timing registers are written through
//   cfg_write / cfg_index / cfg_data while no request is in flight.
// Timing:
//   a request is registered, then processed once the result register can
//   take it; its result is shown from then on. Throughput is one request per
//   cycle while res is not stalled; the state update is a single pass through
//   the decode and duration logic between the request and result registers.
// Reset:
//   rst (synchronous) clears both channel stages, sets the relay off, no
//   mode, and restores the register defaults.
// Stall:
//   while res is stalled the result holds; one further request is taken
//   into the request register, then cmd.ready drops until res drains.
// ----------------------------------------------------------------------------
module relay_pattern_sequencer_unit #(
  parameter int TIME_BITS    = rps_pkg::TIME_BITS_DEF,
  parameter int PRESET_COUNT = rps_pkg::PRESET_COUNT_DEF,
  parameter int PRESET_STEPS = rps_pkg::PRESET_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  rps_stream_if.sink                    cmd,
  rps_stream_if.source                  res,
  input  logic                          cfg_write,
  input  logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rps_pkg::CFG_W-1:0]     cfg_data
);

  rps_pkg::cfg_t     cfg;
  rps_pkg::cmd_req_t req;
  logic              req_valid;
  logic              req_fire;
  rps_pkg::result_t  core_res;
  rps_pkg::result_t  res_data;
  logic              res_valid;

  assign req_fire  = req_valid && (!res_valid || res.ready);
  assign cmd.ready = !req_valid || req_fire;

  rps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rps_seq_core #(
    .TIME_BITS    (TIME_BITS),
    .PRESET_COUNT (PRESET_COUNT),
    .PRESET_STEPS (PRESET_STEPS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (req_fire),
    .req  (req),
    .cfg  (cfg),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        req_valid <= 1'b1;
        req       <= cmd.data;
      end else if (req_fire) begin
        req_valid <= 1'b0;
      end
      if (req_fire) begin
        res_valid <= 1'b1;
        res_data  <= core_res;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule

[hw/rtl/rps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rps_checker
// Port-level checks of the relay pattern sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rps_checker (
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             res_valid,
  input logic             res_ready,
  input rps_pkg::result_t res_data
);

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // a draining receiver never throttles requests
  a_full_rate: assert property (@(posedge clk) disable iff (rst)
    res_ready |-> cmd_ready)
    else $error("request refused while receiver ready");

  // reported mode is always a defined one
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.active_mode <= rps_pkg::MODE_PRESET)
    else $error("undefined active mode");

  // a request taken with an empty pipe yields a result through the request and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !res_valid && res_ready |=> ##1 res_valid)
    else $error("result missing after request");

endmodule

bind relay_pattern_sequencer_unit rps_checker u_rps_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_data  (res.data)
);
